>>> src/rbil_pkg.sv
// Shared types and constants of the radial beam image lookup.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rbil_pkg;
	localparam int TABLE_DEPTH_DEF = 16384;
	localparam int SQRT_DIGITS = 32;
	localparam int SQRT_STEPS_DEF = 2;

	localparam logic [1:0] ACT_WR_A = 2'd0;
	localparam logic [1:0] ACT_WR_B = 2'd1;
	localparam logic [1:0] ACT_PIXEL = 2'd2;

	localparam logic [2:0] CFG_SCALE_X = 3'd0;
	localparam logic [2:0] CFG_SCALE_Y = 3'd1;
	localparam logic [2:0] CFG_OFFSET_X = 3'd2;
	localparam logic [2:0] CFG_OFFSET_Y = 3'd3;
	localparam logic [2:0] CFG_MAX_R2 = 3'd4;
	localparam logic [2:0] CFG_R_SCALE = 3'd5;
	localparam logic [2:0] CFG_BLEND_W = 3'd6;

	typedef struct packed {
		logic pix;
		logic wr_a;
		logic wr_b;
		logic outside;
		logic [13:0] tidx;
		logic [15:0] tval;
	} side_t;
endpackage
`default_nettype wire

>>> src/rbil_geom.sv
// Scale, offset, square and squared radius stages with the radius limit test.
// Depends on rbil_pkg.
`default_nettype none
module rbil_geom (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  rbil_pkg::side_t in_side,
	input  wire logic [15:0] col,
	input  wire logic [15:0] row,
	input  wire logic [31:0] scale_x,
	input  wire logic [31:0] scale_y,
	input  wire logic [63:0] offset_x,
	input  wire logic [63:0] offset_y,
	input  wire logic [62:0] max_r2,
	output logic out_vld,
	output rbil_pkg::side_t out_side,
	output logic [63:0] r2
);
	import rbil_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [47:0] px_s1, py_s1;
	logic signed [65:0] dx_s2, dy_s2;
	logic [65:0] ax, ay;
	logic [31:0] mx_s3, my_s3;
	logic big_s3, big_s4;
	logic [63:0] sx_s4, sy_s4;
	logic [63:0] sum;
	logic [63:0] r2_s5;

	assign ax = dx_s2[65] ? 66'(-dx_s2) : 66'(dx_s2);
	assign ay = dy_s2[65] ? 66'(-dy_s2) : 66'(dy_s2);
	assign sum = sx_s4 + sy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			px_s1 <= 48'(col) * 48'(scale_x);
			py_s1 <= 48'(row) * 48'(scale_y);
			side_s2 <= side_s1;
			dx_s2 <= $signed({18'b0, px_s1}) - $signed({{2{offset_x[63]}}, offset_x});
			dy_s2 <= $signed({18'b0, py_s1}) - $signed({{2{offset_y[63]}}, offset_y});
			side_s3 <= side_s2;
			mx_s3 <= ax[31:0];
			my_s3 <= ay[31:0];
			big_s3 <= (|ax[65:32]) | (|ay[65:32]);
			side_s4 <= side_s3;
			sx_s4 <= 64'(mx_s3) * 64'(mx_s3);
			sy_s4 <= 64'(my_s3) * 64'(my_s3);
			big_s4 <= big_s3;
			side_s5 <= {side_s4.pix, side_s4.wr_a, side_s4.wr_b,
				big_s4 | sx_s4[63] | sy_s4[63] | (sum > {1'b0, max_r2}),
				side_s4.tidx, side_s4.tval};
			r2_s5 <= sum;
		end
	end

	assign out_vld = vld_s5;
	assign out_side = side_s5;
	assign r2 = r2_s5;
endmodule
`default_nettype wire

>>> src/rbil_sqrt.sv
// Pipelined digit-by-digit floor square root of the squared radius.
// Depends on rbil_pkg.
`default_nettype none
module rbil_sqrt #(
	parameter int STEPS = rbil_pkg::SQRT_STEPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  rbil_pkg::side_t in_side,
	input  wire logic [63:0] r2,
	output logic out_vld,
	output rbil_pkg::side_t out_side,
	output logic [31:0] root
);
	import rbil_pkg::*;

	localparam int NST = SQRT_DIGITS / STEPS;

	logic vld_s [NST+1];
	side_t side_s [NST+1];
	logic [34:0] rem_s [NST+1];
	logic [31:0] root_s [NST+1];
	logic [63:0] val_s [NST+1];

	assign vld_s[0] = in_vld;
	assign side_s[0] = in_side;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign val_s[0] = r2;

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic [34:0] rem_n;
		logic [31:0] root_n;
		logic [63:0] val_n;

		always_comb begin
			logic [34:0] shifted;
			logic [34:0] trial;
			rem_n = rem_s[g];
			root_n = root_s[g];
			val_n = val_s[g];
			for (int k = 0; k < STEPS; k++) begin
				shifted = {rem_n[32:0], val_n[63:62]};
				trial = {1'b0, root_n, 2'b01};
				val_n = {val_n[61:0], 2'b00};
				if (shifted >= trial) begin
					rem_n = shifted - trial;
					root_n = {root_n[30:0], 1'b1};
				end else begin
					rem_n = shifted;
					root_n = {root_n[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g+1] <= 1'b0;
			else if (en)
				vld_s[g+1] <= vld_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				rem_s[g+1] <= rem_n;
				root_s[g+1] <= root_n;
				val_s[g+1] <= val_n;
			end
		end
	end

	assign out_vld = vld_s[NST];
	assign out_side = side_s[NST];
	assign root = root_s[NST];
endmodule
`default_nettype wire

>>> src/rbil_lookup.sv
// Table index scaling, profile tables A and B, blend and output register.
// Depends on rbil_pkg.
`default_nettype none
module rbil_lookup #(
	parameter int TABLE_DEPTH = rbil_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  rbil_pkg::side_t in_side,
	input  wire logic [31:0] root,
	input  wire logic [31:0] radius_scale,
	input  wire logic [16:0] blend_weight,
	output logic out_vld,
	output logic [15:0] beam_value,
	output logic outside
);
	import rbil_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	side_t side_s1, side_s2, side_s3, side_s4;
	logic [63:0] prod_s1;
	logic [AW-1:0] addr_s2;
	logic wr_ok_s2;
	logic [15:0] mem_a [TABLE_DEPTH];
	logic [15:0] mem_b [TABLE_DEPTH];
	logic [15:0] a_s3, b_s3;
	logic [32:0] pa_s4, pb_s4;
	logic [16:0] w;
	logic [23:0] idx_w;
	logic [AW-1:0] idx;
	logic [33:0] blend;

	assign w = (blend_weight > 17'd65536) ? 17'd65536 : blend_weight;
	assign idx_w = prod_s1[63:40];
	assign idx = (32'(idx_w) > TABLE_DEPTH - 1) ? AW'(TABLE_DEPTH - 1) : idx_w[AW-1:0];
	assign blend = 34'(pa_s4) + 34'(pb_s4) + 34'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			out_vld <= vld_s4 & side_s4.pix;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			prod_s1 <= 64'(root) * 64'(radius_scale);
			side_s2 <= side_s1;
			addr_s2 <= side_s1.pix ? idx : AW'(side_s1.tidx);
			wr_ok_s2 <= 32'(side_s1.tidx) < TABLE_DEPTH;
			side_s3 <= side_s2;
			if (vld_s2 && side_s2.wr_a && wr_ok_s2)
				mem_a[addr_s2] <= side_s2.tval;
			if (vld_s2 && side_s2.wr_b && wr_ok_s2)
				mem_b[addr_s2] <= side_s2.tval;
			a_s3 <= mem_a[addr_s2];
			b_s3 <= mem_b[addr_s2];
			side_s4 <= side_s3;
			pa_s4 <= 33'(a_s3) * 33'(17'd65536 - w);
			pb_s4 <= 33'(b_s3) * 33'(w);
			beam_value <= side_s4.outside ? 16'd0 : blend[31:16];
			outside <= side_s4.outside;
		end
	end
endmodule
`default_nettype wire

>>> src/radial_beam_image_lookup.sv
// Radial beam image lookup: configuration registers, stream handshake and
// the pipeline of rbil_geom, rbil_sqrt and rbil_lookup. Depends on rbil_pkg.
//
// Use: load profile tables A and B with beats whose tuser is 0 or 1, then
// send pixel beats (tuser 2) carrying column and row. Each pixel beat gives
// one output beat: the blended Q1.15 beam value in tdata and the outside
// flag in tuser. Table writes and tuser 3 give no output beat.
// Configuration must be written over cfg_valid/cfg_index/cfg_data only while no
// beat is in flight; the block itself does not enforce this. cfg_ready is always high.
// Throughput: one beat per cycle while the output is not stalled. The pipeline
// has 5 geometry stages, 32 / SQRT_STEPS root stages and 5 lookup stages.
// Tables are written at the memory stage in stream order, so a pixel sees
// every earlier table write.
// When the receiver stalls the whole pipeline holds and s_tready falls; a
// pending result stays on the output register. Reset clears the configuration
// registers and valid bits; table contents are undefined until written.
`default_nettype none
module radial_beam_image_lookup #(
	parameter int TABLE_DEPTH = rbil_pkg::TABLE_DEPTH_DEF,
	parameter int SQRT_STEPS = rbil_pkg::SQRT_STEPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [63:0] s_tdata, // table_index, table_value, pixel_col, pixel_row
	input  wire logic [1:0] s_tuser,  // action
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [15:0] m_tdata,      // beam_value
	output logic [0:0] m_tuser,       // outside
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	import rbil_pkg::*;

	logic en;
	logic [31:0] scale_x_q, scale_y_q, radius_scale_q;
	logic [63:0] offset_x_q, offset_y_q;
	logic [62:0] max_r2_q;
	logic [16:0] blend_w_q;
	side_t in_side;
	logic g_vld, q_vld;
	side_t g_side, q_side;
	logic [63:0] r2;
	logic [31:0] root;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= '0;
			scale_y_q <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
			max_r2_q <= '0;
			radius_scale_q <= '0;
			blend_w_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCALE_X: scale_x_q <= cfg_data[31:0];
				CFG_SCALE_Y: scale_y_q <= cfg_data[31:0];
				CFG_OFFSET_X: offset_x_q <= cfg_data;
				CFG_OFFSET_Y: offset_y_q <= cfg_data;
				CFG_MAX_R2: max_r2_q <= cfg_data[62:0];
				CFG_R_SCALE: radius_scale_q <= cfg_data[31:0];
				CFG_BLEND_W: blend_w_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_side.pix = s_tuser == ACT_PIXEL;
		in_side.wr_a = s_tuser == ACT_WR_A;
		in_side.wr_b = s_tuser == ACT_WR_B;
		in_side.outside = 1'b0;
		in_side.tidx = s_tdata[13:0];
		in_side.tval = s_tdata[29:14];
	end

	rbil_geom u_geom (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(s_tvalid && s_tready), .in_side(in_side),
		.col(s_tdata[45:30]), .row(s_tdata[61:46]),
		.scale_x(scale_x_q), .scale_y(scale_y_q),
		.offset_x(offset_x_q), .offset_y(offset_y_q), .max_r2(max_r2_q),
		.out_vld(g_vld), .out_side(g_side), .r2(r2)
	);

	rbil_sqrt #(.STEPS(SQRT_STEPS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(g_vld), .in_side(g_side), .r2(r2),
		.out_vld(q_vld), .out_side(q_side), .root(root)
	);

	rbil_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) u_lookup (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(q_vld), .in_side(q_side), .root(root),
		.radius_scale(radius_scale_q), .blend_weight(blend_w_q),
		.out_vld(m_tvalid), .beam_value(m_tdata), .outside(m_tuser[0])
	);
endmodule
`default_nettype wire
